/* rtl/core/tlc_pkg.sv */
// tlc_pkg: types, codes and helper functions of the traffic light controller.
// No dependencies.
`timescale 1ns / 1ps
package tlc_pkg;

  localparam int MaxSecondsDefault = 99;

  typedef enum logic [1:0] {
    MODE_READY = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_EDIT  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    JOB_STOP     = 3'd0,
    JOB_CYCLE    = 3'd1,
    JOB_BLINK    = 3'd2,
    JOB_ADD_HOLD = 3'd3,
    JOB_ADD_REP  = 3'd4,
    JOB_SUB_HOLD = 3'd5,
    JOB_SUB_REP  = 3'd6,
    JOB_SPARE    = 3'd7
  } job_t;

  typedef enum logic [1:0] {
    CFG_YELLOW    = 2'd0,
    CFG_GREEN_MIN = 2'd1,
    CFG_GREEN_MAX = 2'd2,
    CFG_TICKS     = 2'd3
  } cfg_idx_t;

  localparam logic [4:0] BlinkOnEnd     = 5'd2;
  localparam logic [4:0] BlinkOnStart   = 5'd10;
  localparam logic [4:0] EditBlinkTicks = 5'd10;
  localparam logic [4:0] RepeatTicks    = 5'd2;
  localparam int         WarnSeconds    = 5;
  localparam int         SimpleShow     = 10;

  localparam logic [7:0] LampEwGreen  = 8'hdf;
  localparam logic [7:0] LampEwYellow = 8'hbf;
  localparam logic [7:0] LampEwRed    = 8'h7f;
  localparam logic [7:0] LampNsRed    = 8'hed;
  localparam logic [7:0] LampNsGreen  = 8'hfa;
  localparam logic [7:0] LampNsYellow = 8'hf7;
  localparam logic [7:0] LampNsStop   = 8'hfd;

  typedef struct packed {
    logic       kind;
    logic [7:0] keys;
  } tlc_item_t;

  typedef struct packed {
    logic [7:0] lamp_pattern;
    logic       lamp_ew_green_aux;
    logic       lamp_ew_stop_aux;
    logic       buzzer;
    logic [6:0] left_tens_segments;
    logic [6:0] left_ones_segments;
    logic [6:0] right_tens_segments;
    logic [6:0] right_ones_segments;
    logic [1:0] mode_now;
  } tlc_result_t;

  typedef struct packed {
    logic [3:0] yellow_seconds;
    logic [6:0] green_min_seconds;
    logic [6:0] green_max_seconds;
    logic [4:0] ticks_per_second;
  } tlc_cfg_t;

  function automatic logic [6:0] seg_code(input logic [3:0] d);
    logic [6:0] s;
    case (d)
      4'd0: s = 7'h3f;
      4'd1: s = 7'h06;
      4'd2: s = 7'h5b;
      4'd3: s = 7'h4f;
      4'd4: s = 7'h66;
      4'd5: s = 7'h6d;
      4'd6: s = 7'h7d;
      4'd7: s = 7'h07;
      4'd8: s = 7'h7f;
      4'd9: s = 7'h6f;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* rtl/core/tlc_if.sv */
// tlc_if: valid/ready channel interfaces for items, results and configuration.
// Depends on tlc_pkg.
`timescale 1ns / 1ps
interface tlc_in_if import tlc_pkg::*; ();
  logic      valid;
  logic      ready;
  tlc_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlc_out_if import tlc_pkg::*; ();
  logic        valid;
  logic        ready;
  tlc_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tlc_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [6:0]  wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

/* rtl/core/tlc_digits.sv */
// tlc_digits: two-digit seven-segment encoder with blanking and clamping.
// Depends on tlc_pkg.
`timescale 1ns / 1ps
module tlc_digits import tlc_pkg::*; #(
  parameter int MAX_SECONDS = MaxSecondsDefault
) (
  input  logic        blank,
  input  logic [7:0]  value,
  output logic [13:0] codes
);
  logic [7:0] clamped;
  logic [3:0] tens;
  logic [3:0] ones;
  logic [7:0] tens_w;

  always_comb begin
    clamped = (value > 8'(MAX_SECONDS)) ? 8'(MAX_SECONDS) : value;
    // divide by ten via reciprocal, exact for values below 100
    tens_w  = 8'((16'(clamped) * 16'd205) >> 11);
    tens    = tens_w[3:0];
    ones    = 4'(clamped - 8'(tens_w * 8'd10));
    codes   = blank ? 14'd0 : {seg_code(tens), seg_code(ones)};
  end
endmodule

/* rtl/core/tlc_core.sv */
// tlc_core: next-state and output logic of the controller for one transaction.
// Depends on tlc_pkg and tlc_digits.
`timescale 1ns / 1ps
module tlc_core import tlc_pkg::*; #(
  parameter int MAX_SECONDS = MaxSecondsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  tlc_item_t   item,
  input  tlc_cfg_t    cfg,
  output tlc_result_t result
);
  mode_t       mode_r, mode_nxt;
  logic [7:0]  prev_r, prev_nxt, cur_r, cur_nxt;
  logic [6:0]  g_ew_r, g_ew_nxt, g_ns_r, g_ns_nxt;
  logic [7:0]  len_r, len_nxt, pos_r, pos_nxt;
  logic [4:0]  tick_r, tick_nxt;
  job_t        job_r, job_nxt;
  logic [1:0]  tgt_r, tgt_nxt;
  logic        eblink_r, eblink_nxt;
  logic        simple_r, simple_nxt, buzz_r, buzz_nxt, flash_r, flash_nxt;
  logic        beep_r, beep_nxt;
  logic [27:0] dig_r, dig_nxt;
  logic [7:0]  lamp_r, lamp_nxt;
  logic        agr_r, agr_nxt, ast_r, ast_nxt;

  // digit pair requests: [0] = left (ns), [1] = right (ew)
  logic        pair_set [2];
  logic        pair_blank [2];
  logic [7:0]  pair_val [2];
  logic [13:0] pair_code [2];

  for (genvar p = 0; p < 2; p++) begin : g_pair
    tlc_digits #(.MAX_SECONDS(MAX_SECONDS)) u_dig (
      .blank (pair_blank[p]),
      .value (pair_val[p]),
      .codes (pair_code[p])
    );
  end

  logic [7:0] rel, prs;
  logic [4:0] tick_inc;
  logic [8:0] ge, gey, geyg, sum9;
  logic       vis;
  logic       up_dir;
  logic       do_adj;

  always_comb begin
    logic [8:0] rem;
    logic       jump;
    logic [8:0] jpos;
    logic [7:0] pos_mid;

    mode_nxt = mode_r; prev_nxt = prev_r; cur_nxt = cur_r;
    g_ew_nxt = g_ew_r; g_ns_nxt = g_ns_r; len_nxt = len_r; pos_nxt = pos_r;
    tick_nxt = tick_r; job_nxt = job_r; tgt_nxt = tgt_r; eblink_nxt = eblink_r;
    simple_nxt = simple_r; buzz_nxt = buzz_r; flash_nxt = flash_r; beep_nxt = beep_r;
    lamp_nxt = lamp_r; agr_nxt = agr_r; ast_nxt = ast_r;
    pair_set[0] = 1'b0; pair_set[1] = 1'b0;
    pair_blank[0] = 1'b0; pair_blank[1] = 1'b0;
    pair_val[0] = '0; pair_val[1] = '0;
    rel = '0; prs = '0; do_adj = 1'b0; up_dir = 1'b0;
    rem = '0; jump = 1'b0; jpos = '0; pos_mid = pos_r;
    tick_inc = tick_r + 5'd1;
    vis = (tick_r < BlinkOnEnd) || (tick_r >= BlinkOnStart);
    ge   = 9'(g_ew_r);
    gey  = 9'(g_ew_r) + 9'(cfg.yellow_seconds);
    geyg = gey + 9'(g_ns_r);
    sum9 = geyg + 9'(cfg.yellow_seconds);

    if (item.kind) begin
      case (job_r)
        JOB_CYCLE: begin
          tick_nxt = tick_inc;
          if (tick_inc == cfg.ticks_per_second) begin
            tick_nxt = '0;
            pos_nxt = (len_r == 8'd0 || pos_r + 8'd1 == len_r) ? 8'd0 : pos_r + 8'd1;
          end
        end
        JOB_BLINK: begin
          tick_nxt = tick_inc;
          if (tick_inc == EditBlinkTicks) begin
            tick_nxt = '0;
            eblink_nxt = ~eblink_r;
            pair_set[0] = 1'b1; pair_set[1] = 1'b1;
            pair_val[1] = 8'(g_ew_r); pair_val[0] = 8'(g_ns_r);
            if (tgt_r == 2'd1) pair_blank[1] = eblink_r;
            else pair_blank[0] = eblink_r;
          end
        end
        JOB_ADD_HOLD, JOB_SUB_HOLD: begin
          tick_nxt = tick_inc;
          if (tick_inc == cfg.ticks_per_second) begin
            tick_nxt = '0;
            do_adj = 1'b1; up_dir = (job_r == JOB_ADD_HOLD);
            job_nxt = (job_r == JOB_ADD_HOLD) ? JOB_ADD_REP : JOB_SUB_REP;
          end
        end
        JOB_ADD_REP, JOB_SUB_REP: begin
          tick_nxt = tick_inc;
          if (tick_inc == RepeatTicks) begin
            tick_nxt = '0;
            do_adj = 1'b1; up_dir = (job_r == JOB_ADD_REP);
          end
        end
        default: ;
      endcase
    end else begin
      prev_nxt = cur_r;
      cur_nxt  = item.keys;
      rel = ~cur_r & item.keys;
      prs = cur_r & ~item.keys;
      case (mode_r)
        MODE_READY: begin
          pair_set[0] = 1'b1; pair_set[1] = 1'b1;
          pair_val[1] = 8'(g_ew_r); pair_val[0] = 8'(g_ns_r);
          if (rel[0]) begin
            mode_nxt = MODE_RUN;
            len_nxt = (sum9 > 9'd255) ? 8'd255 : sum9[7:0];
            pos_nxt = '0; tick_nxt = '0; job_nxt = JOB_CYCLE;
          end
          if (rel[2]) begin
            // ready always moves to edit target one
            tgt_nxt = 2'd1; mode_nxt = MODE_EDIT;
            tick_nxt = '0; eblink_nxt = 1'b1; job_nxt = JOB_BLINK;
          end
        end
        MODE_RUN: begin
          lamp_nxt = 8'hff; agr_nxt = 1'b1; ast_nxt = 1'b1;
          pair_set[0] = 1'b1; pair_set[1] = 1'b1;
          // east-west side
          if (9'(pos_r) < ge) begin
            flash_nxt = 1'b0;
            rem = ge - 9'(pos_r) - 9'd1;
            pair_val[1] = rem[7:0];
            if (rem >= 9'(WarnSeconds)) begin
              lamp_nxt = lamp_nxt & LampEwGreen; agr_nxt = 1'b0;
              if (!simple_r && buzz_r) beep_nxt = 1'b0;
              pair_blank[1] = simple_r;
            end else if (vis) begin
              lamp_nxt = lamp_nxt & LampEwGreen; agr_nxt = 1'b0;
              if (buzz_r) beep_nxt = ~beep_nxt;
              pair_blank[1] = simple_r;
            end else begin
              if (buzz_r) beep_nxt = 1'b0;
              pair_blank[1] = 1'b1;
            end
          end else if (9'(pos_r) < gey) begin
            rem = gey - 9'(pos_r) - 9'd1;
            pair_val[1] = rem[7:0];
            if (!flash_r || vis) begin
              lamp_nxt = lamp_nxt & LampEwYellow; pair_blank[1] = simple_r;
            end else pair_blank[1] = 1'b1;
            ast_nxt = 1'b0;
          end else begin
            rem = 9'(len_r) - 9'(pos_r) - 9'd1;
            pair_val[1] = rem[7:0];
            pair_blank[1] = (9'(len_r) <= 9'(pos_r)) ||
                            (simple_r && rem > 9'(SimpleShow));
            lamp_nxt = lamp_nxt & LampEwRed; ast_nxt = 1'b0;
          end
          // north-south side
          if (9'(pos_r) < gey) begin
            rem = gey - 9'(pos_r) - 9'd1;
            pair_val[0] = rem[7:0];
            pair_blank[0] = simple_r && rem > 9'(SimpleShow);
            lamp_nxt = lamp_nxt & LampNsRed;
          end else if (9'(pos_r) < geyg) begin
            flash_nxt = 1'b0;
            rem = geyg - 9'(pos_r) - 9'd1;
            pair_val[0] = rem[7:0];
            if (rem >= 9'(WarnSeconds)) begin
              lamp_nxt = lamp_nxt & LampNsGreen; pair_blank[0] = simple_r;
            end else if (vis) begin
              lamp_nxt = lamp_nxt & LampNsGreen;
              if (buzz_r) beep_nxt = ~beep_nxt;
              pair_blank[0] = simple_r;
            end else begin
              if (buzz_r) beep_nxt = 1'b0;
              pair_blank[0] = 1'b1;
            end
          end else begin
            rem = 9'(len_r) - 9'(pos_r) - 9'd1;
            pair_val[0] = rem[7:0];
            if (!flash_r || vis) begin
              lamp_nxt = lamp_nxt & LampNsYellow;
              pair_blank[0] = simple_r || (9'(len_r) <= 9'(pos_r));
            end else pair_blank[0] = 1'b1;
            lamp_nxt = lamp_nxt & LampNsStop;
          end
          if (rel[0]) begin
            mode_nxt = MODE_READY; lamp_nxt = 8'hff; agr_nxt = 1'b1; ast_nxt = 1'b1;
            job_nxt = JOB_STOP;
          end
          // pedestrian keys in order; the east-west key sees the position
          // left by a north-south jump
          if (rel[4] && gey <= 9'(pos_r) && 9'(pos_r) < geyg) begin
            jump = 1'b1; jpos = geyg;
          end
          if (jump) pos_mid = (jpos >= 9'(len_r)) ? 8'd0 : jpos[7:0];
          if (rel[5] && 9'(pos_mid) < ge) begin
            jump = 1'b1; jpos = ge;
          end
          if (jump) begin
            pos_nxt = (jpos >= 9'(len_r)) ? 8'd0 : jpos[7:0];
            tick_nxt = '0; flash_nxt = 1'b1; job_nxt = JOB_CYCLE;
          end
        end
        MODE_EDIT: begin
          if (prs[4] || prs[5]) begin
            do_adj = 1'b1; up_dir = prs[4];
            tick_nxt = '0;
          end
          if (rel[4] || rel[5]) begin
            tick_nxt = '0; eblink_nxt = 1'b1;
            pair_set[0] = 1'b1; pair_set[1] = 1'b1;
          end
          // keys act in order add press, add release, sub press, sub release
          if (rel[5]) job_nxt = JOB_BLINK;
          else if (prs[5]) job_nxt = JOB_SUB_HOLD;
          else if (rel[4]) job_nxt = JOB_BLINK;
          else if (prs[4]) job_nxt = JOB_ADD_HOLD;
          if (rel[2]) begin
            pair_set[0] = 1'b1; pair_set[1] = 1'b1;
            if (tgt_r == 2'd1) begin
              tgt_nxt = 2'd2; mode_nxt = MODE_EDIT;
              tick_nxt = '0; eblink_nxt = 1'b1; job_nxt = JOB_BLINK;
            end else if (tgt_r == 2'd0 || tgt_r == 2'd3) begin
              tgt_nxt = 2'd1; mode_nxt = MODE_EDIT;
              tick_nxt = '0; eblink_nxt = 1'b1; job_nxt = JOB_BLINK;
            end else begin
              tgt_nxt = 2'd0; mode_nxt = MODE_READY; job_nxt = JOB_STOP;
            end
          end
        end
        default: ;
      endcase
      if (rel[1]) simple_nxt = ~simple_nxt;
      if (rel[3]) buzz_nxt = ~buzz_r;
    end

    // both keys pressed in one sample: add, then subtract
    if (do_adj) begin
      if (!item.kind && prs[4] && prs[5]) begin
        // add then subtract on the same value
        if (tgt_r == 2'd1) begin
          g_ew_nxt = (g_ew_r < cfg.green_max_seconds) ? g_ew_r + 7'd1 : g_ew_r;
          g_ew_nxt = (g_ew_nxt > cfg.green_min_seconds) ? g_ew_nxt - 7'd1 : g_ew_nxt;
        end else if (tgt_r == 2'd2) begin
          g_ns_nxt = (g_ns_r < cfg.green_max_seconds) ? g_ns_r + 7'd1 : g_ns_r;
          g_ns_nxt = (g_ns_nxt > cfg.green_min_seconds) ? g_ns_nxt - 7'd1 : g_ns_nxt;
        end
      end else if (tgt_r == 2'd1) begin
        if (up_dir) g_ew_nxt = (g_ew_r < cfg.green_max_seconds) ? g_ew_r + 7'd1 : g_ew_r;
        else        g_ew_nxt = (g_ew_r > cfg.green_min_seconds) ? g_ew_r - 7'd1 : g_ew_r;
      end else if (tgt_r == 2'd2) begin
        if (up_dir) g_ns_nxt = (g_ns_r < cfg.green_max_seconds) ? g_ns_r + 7'd1 : g_ns_r;
        else        g_ns_nxt = (g_ns_r > cfg.green_min_seconds) ? g_ns_r - 7'd1 : g_ns_r;
      end
      pair_set[0] = 1'b1; pair_set[1] = 1'b1;
    end
    if (do_adj || (!item.kind && mode_r == MODE_EDIT && pair_set[0])) begin
      pair_val[1] = 8'(g_ew_nxt); pair_val[0] = 8'(g_ns_nxt);
      pair_blank[0] = 1'b0; pair_blank[1] = 1'b0;
    end

    dig_nxt = dig_r;
    if (pair_set[1]) dig_nxt[13:0]  = pair_code[1];
    if (pair_set[0]) dig_nxt[27:14] = pair_code[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_READY; prev_r <= 8'hff; cur_r <= 8'hff;
      g_ew_r <= 7'd10; g_ns_r <= 7'd10; len_r <= '0; pos_r <= '0;
      tick_r <= '0; job_r <= JOB_STOP; tgt_r <= '0; eblink_r <= 1'b0;
      simple_r <= 1'b0; buzz_r <= 1'b0; flash_r <= 1'b0; beep_r <= 1'b0;
      dig_r <= '0; lamp_r <= 8'hff; agr_r <= 1'b1; ast_r <= 1'b1;
    end else if (step) begin
      mode_r <= mode_nxt; prev_r <= prev_nxt; cur_r <= cur_nxt;
      g_ew_r <= g_ew_nxt; g_ns_r <= g_ns_nxt; len_r <= len_nxt; pos_r <= pos_nxt;
      tick_r <= tick_nxt; job_r <= job_nxt; tgt_r <= tgt_nxt; eblink_r <= eblink_nxt;
      simple_r <= simple_nxt; buzz_r <= buzz_nxt; flash_r <= flash_nxt;
      beep_r <= beep_nxt; dig_r <= dig_nxt; lamp_r <= lamp_nxt;
      agr_r <= agr_nxt; ast_r <= ast_nxt;
    end
  end

  always_comb begin
    result.lamp_pattern        = lamp_nxt;
    result.lamp_ew_green_aux   = agr_nxt;
    result.lamp_ew_stop_aux    = ast_nxt;
    result.buzzer              = beep_nxt;
    result.left_tens_segments  = dig_nxt[27:21];
    result.left_ones_segments  = dig_nxt[20:14];
    result.right_tens_segments = dig_nxt[13:7];
    result.right_ones_segments = dig_nxt[6:0];
    result.mode_now            = mode_nxt;
  end

  logic unused_prev;
  assign unused_prev = ^prev_r;

  a_pos_in_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != 8'd0) |-> (pos_r < len_r)) else $error("cycle position beyond length");
  a_pos_zero_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == 8'd0) |-> (pos_r == 8'd0)) else $error("position moved in empty cycle");
  a_ready_lamps: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(step) && mode_r == MODE_READY && $past(mode_r) == MODE_RUN) |->
    (lamp_r == 8'hff)) else $error("lamps lit after stop");
endmodule

/* rtl/core/traffic_light_controller.sv */
// A result for every accepted transaction appears in the output register in the
// cycle after it is accepted. Throughput: one transaction per cycle; the input is
// taken whenever the output register is empty or being drained the same cycle.
// Reset: rst_n synchronous, active low; lamps off, ready mode, greens 10 s,
// configuration to 3 s yellow, 5..99 s green range, 20 ticks per second.
`timescale 1ns / 1ps
module traffic_light_controller import tlc_pkg::*; #(
  parameter int MAX_SECONDS = MaxSecondsDefault
) (
  input  logic clk,
  input  logic rst_n,
  tlc_in_if.sink    in_ch,
  tlc_out_if.source out_ch,
  tlc_cfg_if.sink   cfg_ch
);
  tlc_cfg_t    cfg_r;
  tlc_result_t res_w;
  tlc_result_t res_r;
  logic        vld_r;
  logic        step;

  // configuration is always writable; it is to be written only while idle, which the block does not enforce
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.yellow_seconds    <= 4'd3;
      cfg_r.green_min_seconds <= 7'd5;
      cfg_r.green_max_seconds <= 7'd99;
      cfg_r.ticks_per_second  <= 5'd20;
    end else if (cfg_ch.valid) begin
      case (cfg_idx_t'(cfg_ch.index))
        CFG_YELLOW:    cfg_r.yellow_seconds    <= cfg_ch.wdata[3:0];
        CFG_GREEN_MIN: cfg_r.green_min_seconds <= cfg_ch.wdata;
        CFG_GREEN_MAX: cfg_r.green_max_seconds <= cfg_ch.wdata;
        CFG_TICKS:     cfg_r.ticks_per_second  <= cfg_ch.wdata[4:0];
        default: ;
      endcase
    end
  end

  // accept while the result slot is free or emptied this cycle
  assign in_ch.ready = !vld_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  tlc_core #(.MAX_SECONDS(MAX_SECONDS)) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_ch.data),
    .cfg    (cfg_r),
    .result (res_w)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (step) vld_r <= 1'b1;
    else if (out_ch.ready) vld_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= res_w;
  end

  assign out_ch.valid = vld_r;
  assign out_ch.data  = res_r;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && !out_ch.ready) |=> (vld_r && $stable(res_r))) else $error("result lost");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> vld_r) else $error("accepted item gave no result");
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (res_r.mode_now != 2'd3)) else $error("bad mode");
endmodule

/* tb/sv/tb_traffic_light_controller.sv */
// Self-checking testbench for traffic_light_controller: random and directed key
// samples and timer ticks, predicted by a scoreboard class. Depends on tlc_pkg and
// the channel interfaces in tlc_if.
`timescale 1ns / 1ps
module tb_traffic_light_controller;
  import tlc_pkg::*;

  localparam int ClkPeriod = 20;
  localparam int WatchdogLimit = 3000;
  localparam int LongHold = 300;
  localparam int ItemsPerPhase = 90;
  localparam logic [7:0] KeysIdle = 8'hff;

  // ---------------------------------------------------------------------------
  // Scoreboard: a cycle-free model of the controller. note_item() advances the
  // model by one accepted transaction and queues the outputs it should produce;
  // check_result() compares an accepted result against the oldest of them.
  // ---------------------------------------------------------------------------
  class light_scoreboard;
    logic [3:0] yel_s;
    logic [6:0] gmin_s, gmax_s;
    logic [4:0] tps;
    mode_t      mode;
    logic [7:0] prev_k, cur_k;
    int         green [2];
    int         clen, cpos;
    logic [4:0] tcnt;
    job_t       job;
    int         etgt;
    bit         eblink, f_simple, f_buzz, f_flash, f_beep;
    logic [6:0] dig [4];
    logic [7:0] lamp;
    bit         aux_g, aux_s;
    logic [6:0] seg_tab [10] = '{7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66,
                                 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f};
    tlc_result_t expected_lights [$];
    int mismatches;

    function new();
      yel_s = 3; gmin_s = 5; gmax_s = 99; tps = 20;
      mode = MODE_READY; prev_k = KeysIdle; cur_k = KeysIdle;
      green[0] = 10; green[1] = 10;
      clen = 0; cpos = 0; tcnt = 0; job = JOB_STOP; etgt = 0;
      eblink = 0; f_simple = 0; f_buzz = 0; f_flash = 0; f_beep = 0;
      foreach (dig[i]) dig[i] = '0;
      lamp = 8'hff; aux_g = 1; aux_s = 1;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [6:0] v);
      case (idx)
        CFG_YELLOW:    yel_s = v[3:0];
        CFG_GREEN_MIN: gmin_s = v;
        CFG_GREEN_MAX: gmax_s = v;
        CFG_TICKS:     tps = v[4:0];
        default: ;
      endcase
    endfunction

    function bit released(int n);
      return !prev_k[n] && cur_k[n];
    endfunction

    function bit pressed(int n);
      return prev_k[n] && !cur_k[n];
    endfunction

    // negative value blanks the digit pair
    function void show_pair(int base, int x);
      if (x < 0) begin
        dig[base] = '0; dig[base+1] = '0;
        return;
      end
      if (x > MaxSecondsDefault) x = MaxSecondsDefault;
      dig[base] = seg_tab[(x / 10) % 10];
      dig[base+1] = seg_tab[x % 10];
    endfunction

    function void show_greens(bit ew, bit ns);
      show_pair(2, ew ? green[0] : -1);
      show_pair(0, ns ? green[1] : -1);
    endfunction

    function void beep_quiet();
      if (f_buzz) f_beep = 0;
    endfunction

    function void beep_flip();
      if (f_buzz) f_beep = !f_beep;
    endfunction

    function void start_cycle();
      int sum;
      sum = green[0] + green[1] + 2 * yel_s;
      mode = MODE_RUN;
      clen = (sum > 255) ? 255 : sum;
      cpos = 0; tcnt = 0; job = JOB_CYCLE;
    endfunction

    function void start_blink();
      tcnt = 0; eblink = 1;
      show_greens(1, 1);
      job = JOB_BLINK;
    endfunction

    function void next_edit();
      etgt = (etgt + 1) % 3;
      job = JOB_STOP;
      show_greens(1, 1);
      if (etgt == 0) mode = MODE_READY;
      else begin
        mode = MODE_EDIT;
        start_blink();
      end
    endfunction

    function void adjust_green(bit up);
      if (etgt == 1 || etgt == 2) begin
        if (up) begin
          if (green[etgt-1] < gmax_s) green[etgt-1]++;
        end else if (green[etgt-1] > gmin_s) green[etgt-1]--;
      end
      show_greens(1, 1);
    endfunction

    function void jump_to(int pos);
      cpos = (pos >= clen) ? 0 : pos;
      tcnt = 0; f_flash = 1; job = JOB_CYCLE;
    endfunction

    function void show_run();
      bit vis;
      int t, g1, g2, y, rem;
      logic [7:0] lp;
      vis = (tcnt < BlinkOnEnd) || (tcnt >= BlinkOnStart);
      t = cpos; g1 = green[0]; g2 = green[1]; y = yel_s;
      lp = 8'hff; aux_g = 1; aux_s = 1;
      // east-west side
      if (t < g1) begin
        f_flash = 0;
        rem = g1 - t - 1;
        if (rem >= WarnSeconds) begin
          lp &= LampEwGreen; aux_g = 0;
          if (!f_simple) beep_quiet();
          show_pair(2, f_simple ? -1 : rem);
        end else if (vis) begin
          lp &= LampEwGreen; aux_g = 0; beep_flip();
          show_pair(2, f_simple ? -1 : rem);
        end else begin
          beep_quiet(); show_pair(2, -1);
        end
      end else if (t < g1 + y) begin
        rem = g1 + y - t - 1;
        if (!f_flash || vis) begin
          lp &= LampEwYellow; show_pair(2, f_simple ? -1 : rem);
        end else show_pair(2, -1);
        aux_s = 0;
      end else begin
        rem = clen - t - 1;
        show_pair(2, (f_simple && rem > SimpleShow) ? -1 : rem);
        lp &= LampEwRed; aux_s = 0;
      end
      // north-south side
      if (t < g1 + y) begin
        rem = g1 + y - t - 1;
        show_pair(0, (f_simple && rem > SimpleShow) ? -1 : rem);
        lp &= LampNsRed;
      end else if (t < g1 + y + g2) begin
        f_flash = 0;
        rem = g1 + y + g2 - t - 1;
        if (rem >= WarnSeconds) begin
          lp &= LampNsGreen; show_pair(0, f_simple ? -1 : rem);
        end else if (vis) begin
          lp &= LampNsGreen; beep_flip(); show_pair(0, f_simple ? -1 : rem);
        end else begin
          beep_quiet(); show_pair(0, -1);
        end
      end else begin
        rem = clen - t - 1;
        if (!f_flash || vis) begin
          lp &= LampNsYellow; show_pair(0, f_simple ? -1 : rem);
        end else show_pair(0, -1);
        lp &= LampNsStop;
      end
      lamp = lp;
    endfunction

    function void on_tick();
      case (job)
        JOB_CYCLE: begin
          tcnt = tcnt + 5'd1;
          if (tcnt == tps) begin
            tcnt = 0;
            cpos = (clen == 0) ? 0 : (cpos + 1) % clen;
          end
        end
        JOB_BLINK: begin
          tcnt = tcnt + 5'd1;
          if (tcnt == EditBlinkTicks) begin
            tcnt = 0; eblink = !eblink;
            if (etgt == 1) show_greens(eblink, 1);
            else show_greens(1, eblink);
          end
        end
        JOB_ADD_HOLD, JOB_SUB_HOLD: begin
          tcnt = tcnt + 5'd1;
          if (tcnt == tps) begin
            tcnt = 0;
            adjust_green(job == JOB_ADD_HOLD);
            job = (job == JOB_ADD_HOLD) ? JOB_ADD_REP : JOB_SUB_REP;
          end
        end
        JOB_ADD_REP, JOB_SUB_REP: begin
          tcnt = tcnt + 5'd1;
          if (tcnt == RepeatTicks) begin
            tcnt = 0;
            adjust_green(job == JOB_ADD_REP);
          end
        end
        default: ;
      endcase
    endfunction

    function void on_keys(logic [7:0] k);
      int g1, g2, y;
      g1 = green[0]; g2 = green[1]; y = yel_s;
      prev_k = cur_k; cur_k = k;
      if (mode == MODE_READY) begin
        show_greens(1, 1);
        if (released(0)) start_cycle();
        if (released(2)) next_edit();
      end else if (mode == MODE_RUN) begin
        show_run();
        if (released(0)) begin
          mode = MODE_READY; lamp = 8'hff; aux_g = 1; aux_s = 1; job = JOB_STOP;
        end
        if (released(4) && g1 + y <= cpos && cpos < g1 + y + g2) jump_to(g1 + y + g2);
        if (released(5) && cpos < g1) jump_to(g1);
      end else if (mode == MODE_EDIT) begin
        if (pressed(4)) begin
          adjust_green(1); tcnt = 0; job = JOB_ADD_HOLD;
        end
        if (released(4)) start_blink();
        if (pressed(5)) begin
          adjust_green(0); tcnt = 0; job = JOB_SUB_HOLD;
        end
        if (released(5)) start_blink();
        if (released(2)) next_edit();
      end
      if (released(1)) f_simple = !f_simple;
      if (released(3)) f_buzz = !f_buzz;
    endfunction

    function void note_item(tlc_item_t it);
      tlc_result_t r;
      if (it.kind) on_tick();
      else on_keys(it.keys);
      r.lamp_pattern = lamp;
      r.lamp_ew_green_aux = aux_g;
      r.lamp_ew_stop_aux = aux_s;
      r.buzzer = f_beep;
      r.left_tens_segments = dig[0];
      r.left_ones_segments = dig[1];
      r.right_tens_segments = dig[2];
      r.right_ones_segments = dig[3];
      r.mode_now = mode;
      expected_lights.push_back(r);
    endfunction

    function void report(string what, int e, int a);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch %s: expected %0h, got %0h", $realtime, what, e, a);
    endfunction

    function void check_result(tlc_result_t a);
      tlc_result_t e;
      if (expected_lights.size() == 0) begin
        report("unexpected result", 0, int'(a.lamp_pattern));
        return;
      end
      e = expected_lights.pop_front();
      if (a.lamp_pattern !== e.lamp_pattern)
        report("lamp_pattern", e.lamp_pattern, a.lamp_pattern);
      if (a.lamp_ew_green_aux !== e.lamp_ew_green_aux)
        report("lamp_ew_green_aux", e.lamp_ew_green_aux, a.lamp_ew_green_aux);
      if (a.lamp_ew_stop_aux !== e.lamp_ew_stop_aux)
        report("lamp_ew_stop_aux", e.lamp_ew_stop_aux, a.lamp_ew_stop_aux);
      if (a.buzzer !== e.buzzer) report("buzzer", e.buzzer, a.buzzer);
      if (a.left_tens_segments !== e.left_tens_segments)
        report("left_tens_segments", e.left_tens_segments, a.left_tens_segments);
      if (a.left_ones_segments !== e.left_ones_segments)
        report("left_ones_segments", e.left_ones_segments, a.left_ones_segments);
      if (a.right_tens_segments !== e.right_tens_segments)
        report("right_tens_segments", e.right_tens_segments, a.right_tens_segments);
      if (a.right_ones_segments !== e.right_ones_segments)
        report("right_ones_segments", e.right_ones_segments, a.right_ones_segments);
      if (a.mode_now !== e.mode_now) report("mode_now", e.mode_now, a.mode_now);
    endfunction
  endclass

  logic clk;
  logic rst_n;
  tlc_in_if  in_ch ();
  tlc_out_if out_ch ();
  tlc_cfg_if cfg_ch ();

  traffic_light_controller dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  light_scoreboard lights_sb = new();
  bit   idle_on;       // random gaps on both sides when set
  bit   hold_req;      // asks the receiver for one long hold-off
  int   quiet_cycles;
  logic [7:0] key_lvl; // present level of the simulated key port

  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // Both channels are sampled at the edge, before any NBA of that step lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) lights_sb.note_item(in_ch.data);
      if (out_ch.valid && out_ch.ready) lights_sb.check_result(out_ch.data);
    end
  end

  // Watchdog: ends the run after a long stretch without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Result side: random stalls per transaction, one long hold-off on request
  // so that the output register fills and the input stalls behind it.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        hold_req = 0;
      end
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // One input transaction, with a random gap before it when idling is on.
  task automatic send_item(logic kind, logic [7:0] keys);
    int gap;
    tlc_item_t it;
    it.kind = kind;
    it.keys = keys;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Leaves valid raised; the caller drops it after the last write.
  task automatic write_reg(cfg_idx_t idx, logic [6:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    lights_sb.set_reg(idx, v);
  endtask

  // Drain: waits until every expected result is in, then idles while the output register empties.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (lights_sb.expected_lights.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Picks one key of K1..K6, pedestrian/adjust keys weighted up so that the
  // running and editing states get exercised.
  function automatic int pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 0;
    if (r < 18) return 1;
    if (r < 33) return 2;
    if (r < 41) return 3;
    if (r < 70) return 4;
    return 5;
  endfunction

  // Mostly timer ticks, else mostly a single press/release of one key; some noise on all eight bits.
  task automatic random_item();
    int r, b;
    r = $urandom_range(0, 99);
    if (r < 58) send_item(1'b1, 8'($urandom));
    else begin
      r = $urandom_range(0, 99);
      if (r < 6) key_lvl = 8'($urandom);
      else if (r < 12) key_lvl[$urandom_range(0, 7)] ^= 1'b1;
      else if ((key_lvl[5:0] != 6'h3f) && ($urandom_range(0, 9) < 7)) begin
        for (b = 0; b < 6; b++) if (!key_lvl[b]) break;
        key_lvl[b] = 1'b1;
      end else key_lvl[pick_key()] = 1'b0;
      send_item(1'b0, key_lvl);
    end
  endtask

  task automatic run_phase(logic [3:0] y, logic [6:0] gmin, logic [6:0] gmax,
                           logic [4:0] t, bit idle, bit hold);
    write_reg(CFG_YELLOW, y);
    write_reg(CFG_GREEN_MIN, gmin);
    write_reg(CFG_GREEN_MAX, gmax);
    write_reg(CFG_TICKS, t);
    cfg_ch.valid <= 1'b0;
    idle_on = idle;
    hold_req = hold;
    repeat (ItemsPerPhase) random_item();
    drain();
  endtask

  initial begin
    logic [8:0] directed [$];
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_YELLOW;
    cfg_ch.wdata <= '0;
    idle_on = 0;
    hold_req = 0;
    key_lvl = KeysIdle;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: start, pedestrian jumps, display and buzzer toggles, stop,
    // edit with add/subtract and hold, all-low and all-high key ports.
    directed = '{9'h100, 9'h0fe, 9'h0ff, 9'h100, 9'h0ef, 9'h0ff, 9'h0df, 9'h0ff,
                 9'h0fd, 9'h0ff, 9'h0f7, 9'h0ff, 9'h0fe, 9'h0ff, 9'h0fb, 9'h0ff,
                 9'h0ef, 9'h100, 9'h1ff, 9'h0ff, 9'h0df, 9'h0ff, 9'h0fb, 9'h0ff,
                 9'h000};
    idle_on = 1;
    foreach (directed[i]) send_item(directed[i][8], directed[i][7:0]);
    send_item(1'b0, KeysIdle);
    drain();

    // Settings: short and long yellow, min above max, odd tick counts.
    run_phase(4'd3, 7'd5, 7'd99, 5'd20, 1, 0);
    run_phase(4'd1, 7'd1, 7'd99, 5'd2, 1, 0);
    run_phase(4'd15, 7'd1, 7'd12, 5'd3, 0, 0);
    run_phase(4'd2, 7'd99, 7'd1, 5'd31, 1, 0);
    run_phase(4'd1, 7'd3, 7'd8, 5'd0, 1, 0);
    run_phase(4'd3, 7'd5, 7'd99, 5'd1, 0, 1);
    run_phase(4'd2, 7'd1, 7'd5, 5'd2, 1, 0);

    if (lights_sb.mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
